// ===== hw/rtl/ascii_motor_command_parser_macros.svh =====
// assertion macros for the ascii motor command parser
`ifndef ASCII_MOTOR_COMMAND_PARSER_MACROS_SVH
`define ASCII_MOTOR_COMMAND_PARSER_MACROS_SVH

`ifndef SYNTH
// property that must hold at every rising clock edge outside reset
`define AMCP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("amcp assertion failed");
// condition in this cycle implies a consequence in the next one
`define AMCP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("amcp assertion failed");
`else
`define AMCP_ASSERT_ALWAYS(lbl, prop)
`define AMCP_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== hw/rtl/amcp_pkg.sv =====
// package for the ascii motor command parser: constants, command codes, decoders
package amcp_pkg;

  localparam int unsigned LineMax = 20;
  localparam int unsigned CountW  = 6;
  localparam logic [CountW-1:0] CountLast = CountW'(LineMax - 1);

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;

  typedef enum logic [3:0] {
    CMD_JV        = 4'd0,
    CMD_AC        = 4'd1,
    CMD_DC        = 4'd2,
    CMD_SP        = 4'd3,
    CMD_PA        = 4'd4,
    CMD_PR        = 4'd5,
    CMD_BAD_WRITE = 4'd6,
    CMD_VX        = 4'd7,
    CMD_PX        = 4'd8,
    CMD_IQ        = 4'd9,
    CMD_BAD_READ  = 4'd10
  } cmd_e;

  function automatic logic is_term(input logic [7:0] b);
    return (b == ChCr) || (b == ChLf) || (b == ChSemi);
  endfunction

  function automatic cmd_e decode_write(input logic [7:0] a, input logic [7:0] b);
    cmd_e c;
    c = CMD_BAD_WRITE;
    if (a == "J" && b == "V") c = CMD_JV;
    else if (a == "A" && b == "C") c = CMD_AC;
    else if (a == "D" && b == "C") c = CMD_DC;
    else if (a == "S" && b == "P") c = CMD_SP;
    else if (a == "P" && b == "A") c = CMD_PA;
    else if (a == "P" && b == "R") c = CMD_PR;
    return c;
  endfunction

  function automatic cmd_e decode_read(input logic [7:0] a, input logic [7:0] b);
    cmd_e c;
    c = CMD_BAD_READ;
    if (a == "V" && b == "X") c = CMD_VX;
    else if (a == "P" && b == "X") c = CMD_PX;
    else if (a == "I" && b == "Q") c = CMD_IQ;
    return c;
  endfunction

endpackage

// ===== hw/rtl/ascii_motor_command_parser.sv =====
// top level of the ascii motor command parser
//
// takes one received character per word on the rx channel and gives one decoded
// motor command word on the cmd channel for each line that holds more than its
// terminator; spaces are dropped and a line ends at cr, lf or semicolon. a
// character is taken in every clock cycle unless held off: each character updates
// the line state registers (count, two letters, write flag, sign flag, operand
// accumulator, overflow flag) in a single pass through a multiply-by-ten add, and
// a line end loads the result register in the same cycle. the result register
// lets the block keep taking characters while a command waits; only a terminator
// that arrives while the result register is full and not being emptied is held
// off for as long as the cmd side stalls. the command is valid in the cycle after
// its terminator is taken. a line is limited to LineMax-1 stored characters;
// further characters are dropped and the command carries too_long.
module ascii_motor_command_parser
  import amcp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         rx_byte_i,
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  output logic [3:0]         command_o,
  output logic signed [31:0] value_o,
  output logic               too_long_o,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i
);

  `include "ascii_motor_command_parser_macros.svh"

  // line state
  logic [CountW-1:0] char_count_q, char_count_d;
  logic [7:0]        first_q, first_d;
  logic [7:0]        second_q, second_d;
  logic              is_write_q, is_write_d;
  logic              is_neg_q, is_neg_d;
  logic [31:0]       acc_q, acc_d;
  logic              overflow_q, overflow_d;

  // result register
  logic              out_valid_q, out_valid_d;
  cmd_e              cmd_q, cmd_d;
  logic [31:0]       value_q, value_d;
  logic              too_long_q, too_long_d;

  logic        term;
  logic        space;
  logic        accept;
  logic [31:0] acc_mac;
  logic [7:0]  second_now;

  assign term  = is_term(rx_byte_i);
  assign space = (rx_byte_i == ChSpace);

  // a terminator needs the result register, any other character does not
  assign rx_ready_o = !out_valid_q || cmd_ready_i || !term;
  assign accept     = rx_valid_i && rx_ready_o;

  // operand update: acc*10 + byte - '0', wrapping at 32 bits, no digit check
  assign acc_mac = (acc_q << 3) + (acc_q << 1) + {24'h0, rx_byte_i} - {24'h0, ChZero};

  // a one-character line takes the terminator itself as its second letter
  assign second_now = (char_count_q == CountW'(1)) ? rx_byte_i : second_q;

  always_comb begin
    char_count_d = char_count_q;
    first_d      = first_q;
    second_d     = second_q;
    is_write_d   = is_write_q;
    is_neg_d     = is_neg_q;
    acc_d        = acc_q;
    overflow_d   = overflow_q;
    out_valid_d  = out_valid_q && !cmd_ready_i;
    cmd_d        = cmd_q;
    value_d      = value_q;
    too_long_d   = too_long_q;

    if (accept && !space) begin
      if (!term) begin
        if (char_count_q >= CountLast) begin
          // line full: drop the character, remember it
          overflow_d = 1'b1;
        end else begin
          case (char_count_q)
            CountW'(0): first_d    = rx_byte_i;
            CountW'(1): second_d   = rx_byte_i;
            CountW'(2): is_write_d = (rx_byte_i == ChEq);
            default: begin
              if (is_write_q) begin
                if (char_count_q == CountW'(3) && rx_byte_i == ChMinus) begin
                  is_neg_d = 1'b1;
                end else begin
                  acc_d = acc_mac;
                end
              end
            end
          endcase
          char_count_d = char_count_q + CountW'(1);
        end
      end else begin
        // line end: emit unless the line held only its terminator
        if (char_count_q != CountW'(0)) begin
          out_valid_d = 1'b1;
          too_long_d  = overflow_q;
          if (is_write_q) begin
            cmd_d   = decode_write(first_q, second_now);
            value_d = is_neg_q ? (32'd0 - acc_q) : acc_q;
          end else begin
            cmd_d   = decode_read(first_q, second_now);
            value_d = 32'd0;
          end
        end
        char_count_d = '0;
        first_d      = 8'h00;
        second_d     = 8'h00;
        is_write_d   = 1'b0;
        is_neg_d     = 1'b0;
        acc_d        = 32'd0;
        overflow_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_count_q <= '0;
      first_q      <= 8'h00;
      second_q     <= 8'h00;
      is_write_q   <= 1'b0;
      is_neg_q     <= 1'b0;
      acc_q        <= 32'd0;
      overflow_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      char_count_q <= char_count_d;
      first_q      <= first_d;
      second_q     <= second_d;
      is_write_q   <= is_write_d;
      is_neg_q     <= is_neg_d;
      acc_q        <= acc_d;
      overflow_q   <= overflow_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload of the result register, no reset needed
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    value_q    <= value_d;
    too_long_q <= too_long_d;
  end

  assign command_o   = cmd_q;
  assign value_o     = value_q;
  assign too_long_o  = too_long_q;
  assign cmd_valid_o = out_valid_q;

  // checks
  `AMCP_ASSERT_NEXT(a_line_end_emits, accept && term && (char_count_q != CountW'(0)), cmd_valid_o)
  `AMCP_ASSERT_NEXT(a_line_end_clears, accept && term, (char_count_q == '0) && (acc_q == 32'd0) && !overflow_q)
  `AMCP_ASSERT_ALWAYS(a_read_value_zero, !cmd_valid_o || (command_o < CMD_VX) || (value_o == 32'sd0))
  `AMCP_ASSERT_ALWAYS(a_full_holds_term, !(out_valid_q && !cmd_ready_i && term) || !rx_ready_o)
  `AMCP_ASSERT_ALWAYS(a_count_bounded, char_count_q <= CountLast)

endmodule

// ===== tb/tb_ascii_motor_command_parser.sv =====
// testbench for the ascii motor command parser: directed and random lines, self-checking
`timescale 1ns / 1ps

module tb_ascii_motor_command_parser;
  import amcp_pkg::*;

  // one decoded command word as the cmd channel should carry it
  typedef struct packed {
    cmd_e        command;
    logic [31:0] value;
    logic        too_long;
  } motor_cmd_t;

  localparam int unsigned TargetItems = 1900;
  // the last words of the run go through with no idling on either side
  localparam int unsigned QuietItems  = 300;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic [7:0]         rx_byte_i   = '0;
  logic               rx_valid_i  = 1'b0;
  logic               rx_ready_o;
  logic [3:0]         command_o;
  logic signed [31:0] value_o;
  logic               too_long_o;
  logic               cmd_valid_o;
  logic               cmd_ready_i = 1'b0;

  // line state of the predictor, cleared at every line end
  logic [CountW-1:0] line_count   = '0;
  logic [7:0]        line_first   = '0;
  logic [7:0]        line_second  = '0;
  logic              line_write   = 1'b0;
  logic              line_neg     = 1'b0;
  logic [31:0]       line_acc     = '0;
  logic              line_dropped = 1'b0;

  motor_cmd_t pending_cmds[$];

  int unsigned err_cnt    = 0;
  int unsigned items_sent = 0;
  int unsigned stall_left = 0;
  bit          idle_en    = 1'b1;

  ascii_motor_command_parser DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_byte_i),
    .rx_valid_i  (rx_valid_i),
    .rx_ready_o  (rx_ready_o),
    .command_o   (command_o),
    .value_o     (value_o),
    .too_long_o  (too_long_o),
    .cmd_valid_o (cmd_valid_o),
    .cmd_ready_i (cmd_ready_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // generous fixed limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  task automatic clear_line();
    line_count   = '0;
    line_first   = '0;
    line_second  = '0;
    line_write   = 1'b0;
    line_neg     = 1'b0;
    line_acc     = '0;
    line_dropped = 1'b0;
  endtask

  function automatic cmd_e write_code(input logic [7:0] a, input logic [7:0] b);
    case ({a, b})
      "JV":    return CMD_JV;
      "AC":    return CMD_AC;
      "DC":    return CMD_DC;
      "SP":    return CMD_SP;
      "PA":    return CMD_PA;
      "PR":    return CMD_PR;
      default: return CMD_BAD_WRITE;
    endcase
  endfunction

  function automatic cmd_e read_code(input logic [7:0] a, input logic [7:0] b);
    case ({a, b})
      "VX":    return CMD_VX;
      "PX":    return CMD_PX;
      "IQ":    return CMD_IQ;
      default: return CMD_BAD_READ;
    endcase
  endfunction

  // advances the line state by one accepted character and queues the command
  // word that a line end produces
  task automatic parse_char(input logic [7:0] b);
    motor_cmd_t cmd_word;
    logic       term;
    term = (b == ChCr) || (b == ChLf) || (b == ChSemi);
    if (b == ChSpace) return;
    if (!term) begin
      // a full line drops the character but remembers it did so
      if (line_count >= CountLast) begin
        line_dropped = 1'b1;
        return;
      end
      case (line_count)
        0: line_first = b;
        1: line_second = b;
        2: line_write = (b == ChEq);
        default: if (line_write) begin
          if (line_count == 3 && b == ChMinus) line_neg = 1'b1;
          else line_acc = line_acc * 10 + 32'(b) - 32'd48;
        end
      endcase
      line_count = line_count + 1'b1;
      return;
    end
    // a bare terminator gives nothing
    if (line_count == 0) begin
      clear_line();
      return;
    end
    // on a one-character line the terminator stands in as second letter
    if (line_count == 1) line_second = b;
    if (line_write) begin
      cmd_word.command = write_code(line_first, line_second);
      cmd_word.value   = line_neg ? (32'd0 - line_acc) : line_acc;
    end else begin
      cmd_word.command = read_code(line_first, line_second);
      cmd_word.value   = '0;
    end
    cmd_word.too_long = line_dropped;
    pending_cmds.push_back(cmd_word);
    clear_line();
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // each command word taken off the cmd channel is held against the oldest
  // prediction
  always @(posedge clk_i) begin : cmd_checker
    motor_cmd_t want;
    if (rst_ni && cmd_valid_o && cmd_ready_i) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected command word %0d value %0d",
                                  command_o, value_o));
      end else begin
        want = pending_cmds.pop_front();
        if (command_o !== want.command)
          report_mismatch($sformatf("command %0d, expected %0d (%s)",
                                    command_o, want.command, want.command.name()));
        if (value_o !== want.value)
          report_mismatch($sformatf("value %0d, expected %0d",
                                    value_o, $signed(want.value)));
        if (too_long_o !== want.too_long)
          report_mismatch($sformatf("too_long %b, expected %b",
                                    too_long_o, want.too_long));
      end
    end
  end

  // cmd side: ready high by default, stalled in random bursts while idling is enabled
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      cmd_ready_i <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(1, 8) - 1;
      cmd_ready_i <= 1'b0;
    end else begin
      cmd_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // offers one character and waits for it to be taken; valid is only lowered
  // for an idle gap in front of the next word, never between two back-to-back
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 8);
    if (gap != 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_byte_i  <= b;
    rx_valid_i <= 1'b1;
    do @(posedge clk_i); while (!rx_ready_o);
    parse_char(b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_term();
    case ($urandom_range(0, 2))
      0:       return ChCr;
      1:       return ChLf;
      default: return ChSemi;
    endcase
  endfunction

  function automatic logic [15:0] pick_pair(input int unsigned idx);
    case (idx)
      0:       return "JV";
      1:       return "AC";
      2:       return "DC";
      3:       return "SP";
      4:       return "PA";
      5:       return "PR";
      6:       return "VX";
      7:       return "PX";
      default: return "IQ";
    endcase
  endfunction

  task automatic test_write_commands();
    send_text("JV=123;");
    send_text("AC=-45\r");
    send_text("DC=7\n");
    send_text("SP=0;");
    send_text("PA=99;");
    send_text("PR=-1;");
    send_text("QZ=5;");
  endtask

  task automatic test_read_commands();
    send_text("VX;");
    send_text("PX\r");
    send_text("IQ\n");
    send_text("VQ;");
  endtask

  // lines that end at or before position 2, a read line with extra characters, bare terminators and blank lines
  task automatic test_short_lines();
    send_text(";");
    send_text("  \n");
    send_text("A;");
    send_text("AB\r");
    send_text("JV;");
    send_text("JVX5;");
  endtask

  task automatic test_operand_edges();
    send_text("AC=;");
    send_text("DC=-;");
    send_text("PA=2147483647;");
    send_text("PR=-2147483648;");
    send_text("SP=4294967296;");
    // a minus past the sign position is just another character
    send_text("JV=1-2;");
    send_text("JV=--5;");
    // extreme byte values inside the operand
    send_text("JV=");
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(ChSemi);
  endtask

  task automatic test_line_overflow();
    // exactly full, then one over
    send_text("PA=1234567890123456;");
    send_text("PA=12345678901234567;");
    send_text("VXXXXXXXXXXXXXXXXXXXXXXXXXXXX;");
    send_text("PR=-12 34 56 78 90 12 34 56 78\r");
  endtask

  // one random line: mostly well-formed commands, some broken or noisy ones
  task automatic send_random_line();
    logic [7:0]  line_q[$];
    logic [15:0] pair;
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // raw noise, may or may not hold a terminator
      n = $urandom_range(1, 25);
      repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
    end else if (kind < 14) begin
      line_q.push_back(pick_term());
    end else if (kind < 19) begin
      line_q.push_back(8'($urandom_range(0, 255)));
      line_q.push_back(pick_term());
    end else begin
      if (kind < 90) pair = pick_pair($urandom_range(0, 8));
      else pair = {8'($urandom_range(8'h41, 8'h5A)), 8'($urandom_range(8'h41, 8'h5A))};
      line_q.push_back(pair[15:8]);
      line_q.push_back(pair[7:0]);
      if ($urandom_range(0, 3) != 0) begin
        line_q.push_back(ChEq);
        if ($urandom_range(0, 2) == 0) line_q.push_back(ChMinus);
        // long operands can run the line past its capacity
        n = (kind < 25) ? $urandom_range(14, 30) : $urandom_range(0, 11);
        repeat (n) begin
          if ($urandom_range(0, 19) == 0) line_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
          else line_q.push_back(ChZero + 8'($urandom_range(0, 9)));
        end
      end else begin
        n = (kind < 25) ? $urandom_range(17, 26) : $urandom_range(0, 2);
        repeat (n) line_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end
      line_q.push_back(pick_term());
    end
    foreach (line_q[i]) begin
      if ($urandom_range(0, 15) == 0) send_byte(ChSpace);
      send_byte(line_q[i]);
    end
  endtask

  task automatic test_random_traffic();
    while (items_sent < TargetItems) begin
      idle_en = (items_sent + QuietItems < TargetItems);
      send_random_line();
    end
  endtask

  initial begin
    clear_line();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_write_commands();
    test_read_commands();
    test_short_lines();
    test_operand_edges();
    test_line_overflow();
    test_random_traffic();

    rx_valid_i <= 1'b0;
    // drain, then keep the clock running to catch any stray command word
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/amcp_pkg.sv
hw/rtl/ascii_motor_command_parser.sv
tb/tb_ascii_motor_command_parser.sv
